[hdl/dsps_pkg.sv]
// dsps_pkg: widths, register codes, item structs and constant tables
// for the dual spiral palette shader.
// No dependencies; every other file of the block imports it.
`default_nettype none

package dsps_pkg;

  // field widths
  localparam int INPUT_PHASE_W = 14;
  localparam int SHADE_W       = 6;
  localparam int PIXEL_W       = 32;
  localparam int REG_W         = 24;
  localparam int CFG_INDEX_W   = 3;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_LAST = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME     = CFG_INDEX_W'(6);

  // phase accumulator and sine table geometry
  localparam int PHASE_BITS   = 14;
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int SINE_QTR     = SINE_ENTRIES / 4;
  localparam int QTR_IDX_W    = $clog2(SINE_QTR + 1);
  localparam int SINE_W       = 16;
  localparam int SINE_AMPL    = 32767;
  localparam real HALF_PI     = 1.5707963267948966;
  localparam real QTR_STEP    = HALF_PI / real'(SINE_QTR);

  // quadrant boundaries, one bit wider than the index so the full turn fits
  localparam logic [SINE_IDX_W:0] QTR_ONE   = (SINE_IDX_W + 1)'(SINE_QTR);
  localparam logic [SINE_IDX_W:0] QTR_TWO   = (SINE_IDX_W + 1)'(2 * SINE_QTR);
  localparam logic [SINE_IDX_W:0] QTR_THREE = (SINE_IDX_W + 1)'(3 * SINE_QTR);
  localparam logic [SINE_IDX_W:0] QTR_FOUR  = (SINE_IDX_W + 1)'(4 * SINE_QTR);

  // frame offsets: floor(frame*176/5) = frame*35 + floor(frame/5)
  localparam int FRAME_NUM     = 176;
  localparam int FRAME_DEN     = 5;
  localparam int INWARD_WHOLE  = FRAME_NUM / FRAME_DEN;
  localparam int DIV_SHIFT     = 26;
  localparam int DIV_MUL       = (1 << DIV_SHIFT) / FRAME_DEN + 1;
  localparam int COUNTER_SHIFT = 4;

  // ramp index
  localparam int SUM_W     = SINE_W + 1;
  localparam int RAMP_GAIN = 63;
  localparam int SCALED_W  = SUM_W + 6;
  localparam int RAMP_W    = 8;
  localparam int RAMP_ONE  = 1 << RAMP_W;
  localparam logic [RAMP_W-1:0] RAMP_CENTRE = RAMP_W'(128);

  // 16.16 fixed point scaling
  localparam int FIX_W    = 16;
  localparam int FIX_ONE  = 1 << FIX_W;
  localparam int ENV_W    = 17;
  localparam int SCALE_W  = 17;
  localparam int SHADE_MAX = 63;
  localparam int SHADE_ENTRIES = 1 << SHADE_W;
  localparam int ENV_ENTRIES   = 1 << RAMP_W;
  localparam int ENV_LAST      = ENV_ENTRIES - 1;
  localparam int ENV_KNOTS     = 6;

  // common span of the envelope segments, every segment width divides it
  localparam longint ENV_SPAN = 15300;
  localparam longint ENV_DEN  = 100 * ENV_LAST * ENV_SPAN;

  // colour ramp
  localparam int CHANNELS   = 3;
  localparam int CHAN_W     = 8;
  localparam int STOP_COUNT = 6;
  localparam int STOP_IDX_W = $clog2(STOP_COUNT);
  localparam logic [STOP_IDX_W-1:0] STOP_LAST = STOP_IDX_W'(STOP_COUNT - 1);
  localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;

  typedef logic [CHANNELS-1:0][CHAN_W-1:0] rgb_t;
  typedef rgb_t [STOP_COUNT-1:0] stop_bank_t;

  // items between the pipeline sections
  typedef struct packed {
    logic [INPUT_PHASE_W-1:0] inward_phase;
    logic [INPUT_PHASE_W-1:0] outward_phase;
    logic [SHADE_W-1:0]       shade_level;
  } pixel_t;

  typedef struct packed {
    logic                     valid;
    logic signed [SINE_W-1:0] sine_a;
    logic signed [SINE_W-1:0] sine_b;
    logic [SHADE_W-1:0]       shade_level;
  } sine_item_t;

  typedef struct packed {
    logic               valid;
    rgb_t               color_a;
    rgb_t               color_b;
    logic [RAMP_W-1:0]  frac;
    logic [ENV_W-1:0]   envelope;
    logic [SCALE_W-1:0] shade_scale;
  } ramp_item_t;

  typedef struct packed {
    logic               valid;
    logic [PIXEL_W-1:0] argb;
  } pixel_item_t;

  // quarter wave sine magnitudes
  typedef logic [SINE_W-2:0] qtr_table_t [0:SINE_QTR];

  function automatic qtr_table_t build_quarter();
    qtr_table_t tbl;
    real x;
    for (int i = 0; i <= SINE_QTR; i++) begin
      x = QTR_STEP * real'(i);
      tbl[i] = (SINE_W - 1)'($rtoi(real'(SINE_AMPL) * $sin(x)));
    end
    tbl[0] = '0;
    tbl[SINE_QTR] = (SINE_W - 1)'(SINE_AMPL);
    return tbl;
  endfunction

  localparam qtr_table_t SINE_QUARTER = build_quarter();

  // full turn lookup folded onto the quarter table
  function automatic logic signed [SINE_W-1:0] sine_value(input logic [SINE_IDX_W-1:0] idx);
    logic [SINE_IDX_W:0] wide;
    logic [SINE_IDX_W:0] off;
    logic negate;
    logic signed [SINE_W-1:0] mag;
    wide = {1'b0, idx};
    priority if (wide < QTR_ONE) begin
      off = wide;
      negate = 1'b0;
    end else if (wide < QTR_TWO) begin
      off = QTR_TWO - wide;
      negate = 1'b0;
    end else if (wide < QTR_THREE) begin
      off = wide - QTR_TWO;
      negate = 1'b1;
    end else begin
      off = QTR_FOUR - wide;
      negate = 1'b1;
    end
    mag = signed'({1'b0, SINE_QUARTER[off[QTR_IDX_W-1:0]]});
    if (negate) begin
      mag = -mag;
    end
    return mag;
  endfunction

  // piecewise linear envelope, floor of 65536 times the curve
  typedef logic [ENV_W-1:0] env_table_t [0:ENV_ENTRIES-1];

  function automatic env_table_t build_env();
    env_table_t tbl;
    int knot_x [ENV_KNOTS];
    int knot_y [ENV_KNOTS];
    int span_mul [ENV_KNOTS-1];
    longint num;
    longint dx;
    int j;
    knot_x = '{0, 20, 38, 55, 75, 100};
    knot_y = '{26, 58, 100, 74, 20, 26};
    // common span over each segment width
    span_mul = '{765, 850, 900, 765, 612};
    j = 0;
    for (int i = 0; i < ENV_ENTRIES; i++) begin
      while (j < ENV_KNOTS - 2 && 100 * i > ENV_LAST * knot_x[j + 1]) begin
        j++;
      end
      dx  = longint'(knot_x[j + 1] - knot_x[j]);
      num = longint'(knot_y[j]) * ENV_LAST * dx
          + longint'(knot_y[j + 1] - knot_y[j])
            * (100 * longint'(i) - ENV_LAST * longint'(knot_x[j]));
      tbl[i] = ENV_W'((num * longint'(span_mul[j]) * FIX_ONE) / ENV_DEN);
    end
    return tbl;
  endfunction

  localparam env_table_t ENV_ROM = build_env();

  // shade level to 16.16 gain, level 63 is unity
  typedef logic [SCALE_W-1:0] scale_table_t [0:SHADE_ENTRIES-1];

  function automatic scale_table_t build_scale();
    scale_table_t tbl;
    for (int i = 0; i < SHADE_ENTRIES; i++) begin
      tbl[i] = SCALE_W'((i * FIX_ONE) / SHADE_MAX);
    end
    return tbl;
  endfunction

  localparam scale_table_t SHADE_SCALE = build_scale();

endpackage

`default_nettype wire

[hdl/dsps_ifs.sv]
// dsps_ifs: valid/ready channel interfaces for pixel input, pixel output
// and configuration writes.
// Depends on dsps_pkg for field widths.
`default_nettype none

interface dsps_pixel_in_if;
  import dsps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [INPUT_PHASE_W-1:0] inward_phase;
  logic [INPUT_PHASE_W-1:0] outward_phase;
  logic [SHADE_W-1:0]       shade_level;
  modport source (output valid, inward_phase, outward_phase, shade_level, input ready);
  modport sink   (input valid, inward_phase, outward_phase, shade_level, output ready);
endinterface

interface dsps_pixel_out_if;
  import dsps_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_argb;
  modport source (output valid, pixel_argb, input ready);
  modport sink   (input valid, pixel_argb, output ready);
endinterface

interface dsps_cfg_if;
  import dsps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [REG_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/dsps_phase.sv]
// dsps_phase: frame offsets, phase add, sine table reads (three stages).
// Depends on dsps_pkg.
`default_nettype none

module dsps_phase (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [dsps_pkg::REG_W-1:0] frame_number,
  input  wire logic                in_valid,
  input  wire dsps_pkg::pixel_t    in_item,
  output logic                     in_ready,
  output dsps_pkg::sine_item_t     out_item,
  input  wire logic                out_ready
);
  import dsps_pkg::*;

  localparam int PROD_W = PHASE_BITS + SINE_IDX_W + 1;

  // frame derived offsets
  logic [2*REG_W-1:0]      frame_prod;
  logic [PHASE_BITS-1:0]   frame_fifth;
  logic [PHASE_BITS-1:0]   inward_off;
  logic [PHASE_BITS-1:0]   counter_off;

  // stage registers
  logic                    s1_valid;
  pixel_t                  s1;
  logic                    s2_valid;
  logic [SINE_IDX_W-1:0]   s2_idx_a;
  logic [SINE_IDX_W-1:0]   s2_idx_b;
  logic [SHADE_W-1:0]      s2_shade;
  logic                    s3_valid;
  logic signed [SINE_W-1:0] s3_sine_a;
  logic signed [SINE_W-1:0] s3_sine_b;
  logic [SHADE_W-1:0]      s3_shade;

  logic                    en1, en2, en3;
  logic [PHASE_BITS-1:0]   ph_a, ph_b;
  logic [PROD_W-1:0]       pos_a, pos_b;

  // stage enables, a stage moves when empty or when the next one moves
  assign en3 = !s3_valid || out_ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign in_ready = en1;

  // floor(frame/5) by reciprocal, registered
  assign frame_prod = (2*REG_W)'(frame_number) * (2*REG_W)'(DIV_MUL);

  always_ff @(posedge clk) begin
    frame_fifth <= PHASE_BITS'(frame_prod >> DIV_SHIFT);
  end

  assign inward_off  = PHASE_BITS'(frame_number) * PHASE_BITS'(INWARD_WHOLE) + frame_fifth;
  assign counter_off = PHASE_BITS'(frame_number << COUNTER_SHIFT);

  // shifted phases and table positions
  assign ph_a  = PHASE_BITS'(s1.inward_phase) - inward_off;
  assign ph_b  = PHASE_BITS'(s1.outward_phase) + counter_off;
  assign pos_a = PROD_W'(ph_a) * PROD_W'(SINE_ENTRIES);
  assign pos_b = PROD_W'(ph_b) * PROD_W'(SINE_ENTRIES);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= in_item;
    end
    if (en2) begin
      s2_idx_a <= SINE_IDX_W'(pos_a >> PHASE_BITS);
      s2_idx_b <= SINE_IDX_W'(pos_b >> PHASE_BITS);
      s2_shade <= s1.shade_level;
    end
    if (en3) begin
      s3_sine_a <= sine_value(s2_idx_a);
      s3_sine_b <= sine_value(s2_idx_b);
      s3_shade  <= s2_shade;
    end
  end

  assign out_item = '{valid: s3_valid, sine_a: s3_sine_a, sine_b: s3_sine_b,
                      shade_level: s3_shade};

endmodule

`default_nettype wire

[hdl/dsps_ramp.sv]
// dsps_ramp: ramp index from the sine sum, stop, envelope and shade lookups
// (two stages). Depends on dsps_pkg.
`default_nettype none

module dsps_ramp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dsps_pkg::stop_bank_t stop_color,
  input  wire dsps_pkg::sine_item_t in_item,
  output logic                      in_ready,
  output dsps_pkg::ramp_item_t      out_item,
  input  wire logic                 out_ready
);
  import dsps_pkg::*;

  localparam int POS_W = RAMP_W + STOP_IDX_W;

  logic signed [SUM_W-1:0]    sine_sum;
  logic signed [SCALED_W-1:0] scaled;

  logic                   s4_valid;
  logic [RAMP_W-1:0]      s4_idx;
  logic [SHADE_W-1:0]     s4_shade;
  logic                   s5_valid;
  rgb_t                   s5_color_a;
  rgb_t                   s5_color_b;
  logic [RAMP_W-1:0]      s5_frac;
  logic [ENV_W-1:0]       s5_env;
  logic [SCALE_W-1:0]     s5_scale;

  logic                   en4, en5;
  logic [POS_W-1:0]       pos;
  logic [STOP_IDX_W-1:0]  stop_lo;
  logic [STOP_IDX_W-1:0]  stop_hi;

  assign en5 = !s5_valid || out_ready;
  assign en4 = !s4_valid || en5;
  assign in_ready = en4;

  // sum of both sines times 63, floored sixteen bits down, centred
  assign sine_sum = SUM_W'(in_item.sine_a) + SUM_W'(in_item.sine_b);
  assign scaled   = SCALED_W'(sine_sum) * SCALED_W'(RAMP_GAIN);

  // place on the looping six stop ramp
  assign pos     = POS_W'(s4_idx) * POS_W'(STOP_COUNT);
  assign stop_lo = pos[RAMP_W +: STOP_IDX_W];
  assign stop_hi = (stop_lo == STOP_LAST) ? '0 : stop_lo + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (en4) begin
        s4_valid <= in_item.valid;
      end
      if (en5) begin
        s5_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_idx   <= RAMP_W'(scaled >>> FIX_W) + RAMP_CENTRE;
      s4_shade <= in_item.shade_level;
    end
    if (en5) begin
      s5_color_a <= stop_color[stop_lo];
      s5_color_b <= stop_color[stop_hi];
      s5_frac    <= pos[RAMP_W-1:0];
      s5_env     <= ENV_ROM[s4_idx];
      s5_scale   <= SHADE_SCALE[s4_shade];
    end
  end

  assign out_item = '{valid: s5_valid, color_a: s5_color_a, color_b: s5_color_b,
                      frac: s5_frac, envelope: s5_env, shade_scale: s5_scale};

endmodule

`default_nettype wire

[hdl/dsps_shade.sv]
// dsps_shade: per channel blend between stops, envelope and shade gains,
// ARGB packing (three stages). Depends on dsps_pkg.
`default_nettype none

module dsps_shade (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dsps_pkg::ramp_item_t in_item,
  output logic                      in_ready,
  output dsps_pkg::pixel_item_t     out_item,
  input  wire logic                 out_ready
);
  import dsps_pkg::*;

  localparam int MIX_W = CHAN_W + RAMP_W + 1;
  localparam int ENV_PROD_W = CHAN_W + ENV_W;
  localparam int GAIN_PROD_W = CHAN_W + SCALE_W;

  logic               s6_valid;
  rgb_t               s6_chan;
  logic [ENV_W-1:0]   s6_env;
  logic [SCALE_W-1:0] s6_scale;
  logic               s7_valid;
  rgb_t               s7_chan;
  logic [SCALE_W-1:0] s7_scale;
  logic               s8_valid;
  rgb_t               s8_chan;

  logic en6, en7, en8;

  logic [MIX_W-1:0]       mix      [CHANNELS];
  logic [ENV_PROD_W-1:0]  env_prod [CHANNELS];
  logic [GAIN_PROD_W-1:0] gain_prod[CHANNELS];
  rgb_t                   mix_chan;
  rgb_t                   env_chan;
  rgb_t                   gain_chan;

  assign en8 = !s8_valid || out_ready;
  assign en7 = !s7_valid || en8;
  assign en6 = !s6_valid || en7;
  assign in_ready = en6;

  // channel lanes: blend, envelope gain, shade gain
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      mix[ch] = MIX_W'(in_item.color_a[ch]) * (MIX_W'(RAMP_ONE) - MIX_W'(in_item.frac))
              + MIX_W'(in_item.color_b[ch]) * MIX_W'(in_item.frac);
      mix_chan[ch] = CHAN_W'(mix[ch] >> RAMP_W);
      env_prod[ch] = ENV_PROD_W'(s6_chan[ch]) * ENV_PROD_W'(s6_env);
      env_chan[ch] = CHAN_W'(env_prod[ch] >> FIX_W);
      gain_prod[ch] = GAIN_PROD_W'(s7_chan[ch]) * GAIN_PROD_W'(s7_scale);
      gain_chan[ch] = CHAN_W'(gain_prod[ch] >> FIX_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else begin
      if (en6) begin
        s6_valid <= in_item.valid;
      end
      if (en7) begin
        s7_valid <= s6_valid;
      end
      if (en8) begin
        s8_valid <= s7_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_chan  <= mix_chan;
      s6_env   <= in_item.envelope;
      s6_scale <= in_item.shade_scale;
    end
    if (en7) begin
      s7_chan  <= env_chan;
      s7_scale <= s6_scale;
    end
    if (en8) begin
      s8_chan <= gain_chan;
    end
  end

  // opaque alpha over red, green, blue
  assign out_item = '{valid: s8_valid, argb: {ALPHA, s8_chan}};

endmodule

`default_nettype wire

[hdl/dual_spiral_palette_shader.sv]
// dual_spiral_palette_shader: top level, configuration registers and the
// eight stage pixel pipeline. Depends on dsps_pkg, dsps_ifs, dsps_phase,
// dsps_ramp and dsps_shade.
// Throughput: one pixel per clock while the output is ready; each stage moves
// when it is empty or its successor moves, so bubbles close up under output
// stalls.
// The frame_number register feeds a registered reciprocal multiply, so a new
// frame value applies to pixels accepted from the next cycle on.
// Reset (synchronous, active high) clears the configuration registers and the
// valid bits but not the stage payloads; the sine, envelope and shade tables are constant, with no clearing pass.
`default_nettype none

module dual_spiral_palette_shader (
  input  wire logic        clk,
  input  wire logic        rst,
  dsps_pixel_in_if.sink    pixel_in,
  dsps_pixel_out_if.source pixel_out,
  dsps_cfg_if.sink         cfg
);
  import dsps_pkg::*;

  stop_bank_t       stop_color;
  logic [REG_W-1:0] frame_number;

  pixel_t      in_pixel;
  sine_item_t  sine_item;
  logic        ramp_ready;
  ramp_item_t  ramp_item;
  logic        shade_ready;
  pixel_item_t out_item;

  // configuration registers, writes beyond the list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_color   <= '0;
      frame_number <= '0;
    end else if (cfg.valid) begin
      priority if (cfg.index == REG_FRAME) begin
        frame_number <= cfg.data;
      end else if (cfg.index <= REG_STOP_LAST) begin
        stop_color[cfg.index] <= cfg.data;
      end
    end
  end

  assign in_pixel = '{inward_phase: pixel_in.inward_phase,
                      outward_phase: pixel_in.outward_phase,
                      shade_level: pixel_in.shade_level};

  dsps_phase u_phase (
    .clk          (clk),
    .rst          (rst),
    .frame_number (frame_number),
    .in_valid     (pixel_in.valid),
    .in_item      (in_pixel),
    .in_ready     (pixel_in.ready),
    .out_item     (sine_item),
    .out_ready    (ramp_ready)
  );

  dsps_ramp u_ramp (
    .clk        (clk),
    .rst        (rst),
    .stop_color (stop_color),
    .in_item    (sine_item),
    .in_ready   (ramp_ready),
    .out_item   (ramp_item),
    .out_ready  (shade_ready)
  );

  dsps_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .in_item   (ramp_item),
    .in_ready  (shade_ready),
    .out_item  (out_item),
    .out_ready (pixel_out.ready)
  );

  assign pixel_out.valid      = out_item.valid;
  assign pixel_out.pixel_argb = out_item.argb;

endmodule

`default_nettype wire

[verif/tb_dual_spiral_palette_shader.sv]
// tb_dual_spiral_palette_shader: self-checking testbench for the dual spiral
// palette shader, with its own bit-exact pixel predictor and a result queue.
// Depends on dsps_pkg, dsps_ifs and the dual_spiral_palette_shader RTL.

module tb_dual_spiral_palette_shader;
  timeunit 1ns;
  timeprecision 1ps;
  import dsps_pkg::*;

  // register index past the end of the list, writes to it are dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(7);
  // pi/2 in unsigned Q60
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam int LONG_HOLD = 300;

  logic clk;
  logic rst;

  dsps_pixel_in_if  pix_in ();
  dsps_pixel_out_if pix_out ();
  dsps_cfg_if       cfg_ch ();

  dual_spiral_palette_shader u_top (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pix_in),
    .pixel_out (pix_out),
    .cfg       (cfg_ch)
  );

  // predictor copies of the tables and registers
  int                 sine_lut [SINE_ENTRIES];
  int unsigned        envelope_lut [ENV_ENTRIES];
  logic [REG_W-1:0]   stop_regs [STOP_COUNT];
  logic [REG_W-1:0]   frame_reg;

  pixel_t             pending_pixels [$];
  logic [PIXEL_W-1:0] expected_argb [$];
  pixel_t             next_px;

  int send_idle_pct;
  int recv_idle_pct;
  int send_gap;
  int stall_left;
  int long_hold_req;
  int long_hold_done;
  int fault_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // (a*b) >> 60, unsigned
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // sine and envelope tables, built exactly
  initial begin : rom_build
    logic [63:0] x, x2, term, series, qn, k;
    int quarter_mag [SINE_ENTRIES/4 + 1];
    int knot_x [6];
    int knot_y [6];
    int seg;
    longint dx, num, den;
    qn = SINE_ENTRIES / 4;
    for (int i = 0; i <= SINE_ENTRIES / 4; i++) begin
      x = (HALF_PI_Q60 / qn) * i + ((HALF_PI_Q60 % qn) * i) / qn;
      // taylor series in Q60
      x2 = q60_mul(x, x);
      term = x;
      series = x;
      for (k = 1; k < 40; k++) begin
        term = q60_mul(term, x2) / ((2 * k) * (2 * k + 1));
        if (term == 0) break;
        if (k[0]) series = series - term;
        else series = series + term;
      end
      quarter_mag[i] = int'(q60_mul(series, 64'd32767));
    end
    quarter_mag[0] = 0;
    quarter_mag[SINE_ENTRIES/4] = 32767;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      if (i < 2 * qn) begin
        sine_lut[i] = quarter_mag[(i <= qn) ? i : 2 * qn - i];
      end else begin
        sine_lut[i] = -quarter_mag[(i - 2 * qn <= qn) ? i - 2 * qn : 4 * qn - i];
      end
    end
    // envelope, piecewise linear through fixed knots
    knot_x = '{0, 20, 38, 55, 75, 100};
    knot_y = '{26, 58, 100, 74, 20, 26};
    seg = 0;
    for (int i = 0; i < ENV_ENTRIES; i++) begin
      while (seg < 4 && 100 * i > 255 * knot_x[seg + 1]) seg++;
      dx  = knot_x[seg + 1] - knot_x[seg];
      num = longint'(knot_y[seg]) * 255 * dx
          + longint'(knot_y[seg + 1] - knot_y[seg]) * (100 * longint'(i) - 255 * longint'(knot_x[seg]));
      den = 100 * 255 * dx;
      envelope_lut[i] = (num * 65536) / den;
    end
  end

  // one colour channel: interpolate, envelope, shade
  function automatic logic [CHAN_W-1:0] ramp_channel(input int unsigned a, input int unsigned b,
                                                     input int unsigned frac, input int unsigned env,
                                                     input int unsigned gain);
    int unsigned c;
    c = (a * (256 - frac) + b * frac) >> 8;
    c = (c * env) >> 16;
    return CHAN_W'((c * gain) >> 16);
  endfunction

  // expected output pixel for the current register settings
  function automatic logic [PIXEL_W-1:0] shade_pixel(input pixel_t px);
    longint unsigned mask, fr, in_off, out_off, ph_a, ph_b, ia, ib;
    int total, fl;
    int unsigned ramp, pos, seg, frac, env, gain;
    logic [REG_W-1:0] ca, cb;
    mask = (64'd1 << PHASE_BITS) - 1;
    fr = frame_reg;
    // inward offset from the exact rational 176/5, counter offset 16 per frame
    in_off  = (mask + 1) - ((fr * 176 / 5) & mask);
    out_off = (fr * 16) & mask;
    ph_a = (px.inward_phase + in_off) & mask;
    ph_b = (px.outward_phase + out_off) & mask;
    ia = ((ph_a * SINE_ENTRIES) >> PHASE_BITS) % SINE_ENTRIES;
    ib = ((ph_b * SINE_ENTRIES) >> PHASE_BITS) % SINE_ENTRIES;
    total = (sine_lut[ia] + sine_lut[ib]) * 63;
    fl = total >>> 16;
    ramp = (fl + 128) & 255;
    // six looping stops over the 8-bit ramp
    pos  = ramp * 6;
    seg  = pos >> 8;
    frac = pos & 255;
    ca = stop_regs[seg % STOP_COUNT];
    cb = stop_regs[(seg + 1) % STOP_COUNT];
    env = envelope_lut[ramp];
    gain = (32'(px.shade_level) * 65536) / 63;
    return {ALPHA,
            ramp_channel(ca[23:16], cb[23:16], frac, env, gain),
            ramp_channel(ca[15:8], cb[15:8], frac, env, gain),
            ramp_channel(ca[7:0], cb[7:0], frac, env, gain)};
  endfunction

  // random gap: mostly none, some short, a few long
  function automatic int pick_gap(input int idle_pct);
    int r;
    if ($urandom_range(99) >= idle_pct) return 0;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // field value with the extremes weighted up
  function automatic int unsigned pick_value(input int unsigned top);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(top);
  endfunction

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  task automatic queue_pixel(input int unsigned inw, input int unsigned outw,
                             input int unsigned lvl);
    pixel_t px;
    px.inward_phase  = INPUT_PHASE_W'(inw);
    px.outward_phase = INPUT_PHASE_W'(outw);
    px.shade_level   = SHADE_W'(lvl);
    pending_pixels.push_back(px);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_FRAME) frame_reg = val;
    else if (idx <= REG_STOP_LAST) stop_regs[idx] = val;
    cfg_ch.valid <= 1'b0;
  endtask

  // sender quiet and every result back, looked at between edges once the driver has settled
  task automatic wait_all_done();
    while (pending_pixels.size() != 0 || pix_in.valid || expected_argb.size() != 0)
      @(negedge clk);
  endtask

  // pixel driver, predicts each item as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        next_px.inward_phase  = pix_in.inward_phase;
        next_px.outward_phase = pix_in.outward_phase;
        next_px.shade_level   = pix_in.shade_level;
        expected_argb.push_back(shade_pixel(next_px));
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_in.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          next_px = pending_pixels.pop_front();
          pix_in.inward_phase  <= next_px.inward_phase;
          pix_in.outward_phase <= next_px.outward_phase;
          pix_in.shade_level   <= next_px.shade_level;
          pix_in.valid <= 1'b1;
          send_gap = pick_gap(send_idle_pct);
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // output ready, random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
      stall_left = 0;
    end else if (long_hold_req != long_hold_done) begin
      long_hold_done++;
      stall_left = LONG_HOLD;
      pix_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
      stall_left = pick_gap(recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (expected_argb.size() == 0) begin
        log_fault($sformatf("unexpected pixel %h", pix_out.pixel_argb));
      end else if (expected_argb[0] !== pix_out.pixel_argb) begin
        log_fault($sformatf("pixel expected %h got %h", expected_argb[0], pix_out.pixel_argb));
        void'(expected_argb.pop_front());
      end else begin
        void'(expected_argb.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    int send_mix [7];
    int recv_mix [7];
    logic [REG_W-1:0] value;
    logic [REG_W-1:0] stop_set [STOP_COUNT];
    send_mix = '{0, 0, 30, 50, 10, 25, 40};
    recv_mix = '{0, 25, 30, 10, 50, 25, 40};
    stop_set = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF};
    fault_count = 0;
    long_hold_req = 0;
    long_hold_done = 0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    frame_reg = '0;
    for (int i = 0; i < STOP_COUNT; i++) stop_regs[i] = '0;
    rst = 1'b1;
    pix_in.valid = 1'b0;
    pix_in.inward_phase = '0;
    pix_in.outward_phase = '0;
    pix_in.shade_level = '0;
    pix_out.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset
    queue_pixel(0, 0, 63);
    queue_pixel(16383, 16383, 63);
    queue_pixel(4096, 12288, 0);
    wait_all_done();

    // distinct primary and secondary colours on the stops, frame zero
    for (int i = 0; i < STOP_COUNT; i++) write_reg(CFG_INDEX_W'(i), stop_set[i]);
    write_reg(REG_FRAME, '0);
    queue_pixel(0, 0, 0);
    queue_pixel(16383, 16383, 63);
    queue_pixel(0, 16383, 63);
    queue_pixel(16383, 0, 31);
    // sine peaks and troughs: ramp top, bottom and centre
    queue_pixel(4096, 4096, 63);
    queue_pixel(12288, 12288, 63);
    queue_pixel(4096, 12288, 63);
    queue_pixel(8192, 8192, 63);
    queue_pixel(2048, 6144, 63);
    queue_pixel(16, 15, 1);
    queue_pixel(15, 16, 62);
    queue_pixel(14'h2AAA, 14'h1555, 6'h2A);
    queue_pixel(14'h1555, 14'h2AAA, 6'h15);
    queue_pixel(4095, 12289, 32);
    wait_all_done();

    // frame where the inward offset is not a whole step
    write_reg(REG_FRAME, REG_W'(7));
    queue_pixel(0, 0, 63);
    queue_pixel(16383, 4096, 63);
    queue_pixel(12288, 16383, 40);
    wait_all_done();

    // random phases over several register settings
    for (int ph = 0; ph < 7; ph++) begin
      for (int s = 0; s < STOP_COUNT; s++) begin
        case (ph)
          0: value = '1;
          2: value = '0;
          default: value = REG_W'($urandom);
        endcase
        write_reg(CFG_INDEX_W'(s), value);
      end
      case (ph)
        0: value = '1;
        2: value = '0;
        3: value = REG_W'($urandom_range(40));
        default: value = REG_W'($urandom);
      endcase
      write_reg(REG_FRAME, value);
      if (ph == 2) write_reg(REG_UNUSED, REG_W'($urandom));
      send_idle_pct = send_mix[ph];
      recv_idle_pct = recv_mix[ph];
      // long output hold-off while the sender keeps offering
      if (ph == 1) long_hold_req++;
      repeat (100) begin
        queue_pixel(pick_value(16383), pick_value(16383), pick_value(63));
      end
      wait_all_done();
    end

    repeat (30) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
